FILE: src/ipv4p_pkg.sv
// ipv4p_pkg: types, character codes and per-character parse functions for the
// dotted IPv4 text parser. No dependencies.
package ipv4p_pkg;

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_SPACE  = 3'd1;
   localparam logic [2:0] PH_SIGNED = 3'd2;
   localparam logic [2:0] PH_ZERO   = 3'd3;
   localparam logic [2:0] PH_XPFX   = 3'd4;
   localparam logic [2:0] PH_DIGITS = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;

   localparam logic [1:0] RX_DEC = 2'd0;
   localparam logic [1:0] RX_OCT = 2'd1;
   localparam logic [1:0] RX_HEX = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_RANGE  = 2'd1;
   localparam logic [1:0] ST_SYNTAX = 2'd2;
   localparam logic [1:0] ST_COUNT  = 2'd3;

   localparam logic [8:0] PART_LIMIT = 9'd256;
   localparam logic [2:0] PART_MAX   = 3'd4;
   localparam logic [4:0] NO_DIGIT   = 5'd16;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_X  = 8'h78;

   typedef struct packed {
      logic [2:0]      phase;
      logic [1:0]      radix;
      logic            negative;
      logic [8:0]      part_value;
      logic [2:0]      parts_done;
      logic [3:0][7:0] bytes;
      logic [1:0]      error_code;
   } state_type;

   // status sits in the low bits when packed
   typedef struct packed {
      logic [2:0]  part_count;
      logic [31:0] address;
      logic [1:0]  status;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase: PH_START, radix: RX_DEC, negative: 1'b0, part_value: 9'd0,
      parts_done: 3'd0, bytes: 32'd0, error_code: ST_OK};

   function automatic logic is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic [4:0] digit_of(logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         t = c - CH_ZERO;
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
         t = c - CH_LO_A + 8'd10;
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         t = c - CH_UP_A + 8'd10;
      end else begin
         t = {3'd0, NO_DIGIT};
      end
      return t[4:0];
   endfunction

   function automatic logic [4:0] base_of(logic [1:0] r);
      logic [4:0] b;
      case (r)
         RX_HEX:  b = 5'd16;
         RX_OCT:  b = 5'd8;
         default: b = 5'd10;
      endcase
      return b;
   endfunction

   function automatic state_type fail(state_type s, logic [1:0] code);
      state_type r;
      r = s;
      if (s.error_code == ST_OK) r.error_code = code;
      r.phase = PH_DONE;
      return r;
   endfunction

   // part closes at character c; NUL means end of string
   function automatic state_type end_part(state_type s, logic [7:0] c);
      state_type r;
      r = s;
      if (s.part_value >= PART_LIMIT || (s.negative && s.part_value != 9'd0)) begin
         r = fail(s, ST_RANGE);
      end else if (c != CH_DOT && c != CH_NUL) begin
         r = fail(s, ST_SYNTAX);
      end else begin
         r.bytes[s.parts_done[1:0]] = s.part_value[7:0];
         r.parts_done = s.parts_done + 3'd1;
         r.part_value = 9'd0;
         r.negative   = 1'b0;
         r.radix      = RX_DEC;
         r.phase = (c == CH_DOT && r.parts_done < PART_MAX) ? PH_START : PH_DONE;
      end
      return r;
   endfunction

   function automatic state_type end_string(state_type s);
      state_type r;
      r = s;
      case (s.phase)
         PH_START:                      r.phase = PH_DONE;
         PH_SPACE, PH_SIGNED, PH_XPFX:  r = fail(s, ST_SYNTAX);
         PH_ZERO, PH_DIGITS:            r = end_part(s, CH_NUL);
         default:                       r = s;
      endcase
      return r;
   endfunction

   function automatic state_type feed(state_type s, logic [7:0] c);
      state_type   r;
      logic [4:0]  d;
      logic [12:0] scaled;
      logic [12:0] v;
      r      = s;
      d      = digit_of(c);
      scaled = 13'd0;
      v      = 13'd0;
      case (s.phase)
         PH_START, PH_SPACE: begin
            if (is_blank(c)) begin
               r.phase = PH_SPACE;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
               r.negative = (c == CH_MINUS);
               r.phase    = PH_SIGNED;
            end else if (c == CH_ZERO) begin
               r.phase = PH_ZERO;
            end else if (c >= CH_ONE && c <= CH_NINE) begin
               r.radix      = RX_DEC;
               r.part_value = 9'(d);
               r.phase      = PH_DIGITS;
            end else if (s.phase == PH_START && c == CH_DOT) begin
               r = end_part(s, c);
            end else begin
               r = fail(s, ST_SYNTAX);
            end
         end
         PH_SIGNED: begin
            if (c == CH_ZERO) begin
               r.phase = PH_ZERO;
            end else if (c >= CH_ONE && c <= CH_NINE) begin
               r.radix      = RX_DEC;
               r.part_value = 9'(d);
               r.phase      = PH_DIGITS;
            end else begin
               r = fail(s, ST_SYNTAX);
            end
         end
         PH_ZERO: begin
            if (c == CH_LO_X || c == CH_UP_X) begin
               r.phase = PH_XPFX;
            end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
               r.radix      = RX_OCT;
               r.part_value = 9'(d);
               r.phase      = PH_DIGITS;
            end else begin
               r = end_part(s, c);
            end
         end
         PH_XPFX: begin
            if (d < NO_DIGIT) begin
               r.radix      = RX_HEX;
               r.part_value = 9'(d);
               r.phase      = PH_DIGITS;
            end else begin
               r = fail(s, ST_SYNTAX);
            end
         end
         PH_DIGITS: begin
            if (d < base_of(s.radix)) begin
               case (s.radix)
                  RX_HEX:  scaled = {s.part_value, 4'd0};
                  RX_OCT:  scaled = {1'b0, s.part_value, 3'd0};
                  default: scaled = {1'b0, s.part_value, 3'd0} + {3'd0, s.part_value, 1'b0};
               endcase
               v = scaled + 13'(d);
               r.part_value = (v > 13'(PART_LIMIT)) ? PART_LIMIT : v[8:0];
            end else begin
               r = end_part(s, c);
            end
         end
         default: r = s;
      endcase
      return r;
   endfunction

   // classful widening of short forms
   function automatic result_type build_result(state_type s);
      result_type  res;
      logic [7:0]  a0, a1, a2, a3;
      logic [1:0]  cls;
      logic [1:0]  st;
      a0  = s.bytes[0];
      a1  = s.bytes[1];
      a2  = s.bytes[2];
      a3  = s.bytes[3];
      cls = a0[7:6];
      st  = s.error_code;
      if (st == ST_OK) begin
         if (s.parts_done == PART_MAX) begin
            a0 = s.bytes[0];
         end else if (cls <= 2'd1 && s.parts_done == 3'd3) begin
            a3 = s.bytes[2];
            a2 = s.bytes[1];
            a1 = 8'd0;
         end else if (cls <= 2'd1 && s.parts_done == 3'd2) begin
            a3 = s.bytes[1];
            a2 = 8'd0;
            a1 = 8'd0;
         end else if (cls == 2'd2 && s.parts_done == 3'd3) begin
            a3 = s.bytes[2];
            a2 = 8'd0;
         end else begin
            st = ST_COUNT;
         end
      end
      res.status     = st;
      res.address    = (st == ST_OK) ? {a0, a1, a2, a3} : 32'd0;
      res.part_count = s.parts_done;
      return res;
   endfunction

endpackage

FILE: src/ipv4_dotted_text_parser.sv
// ipv4_dotted_text_parser: streams IPv4 dotted text one byte per request and
// returns one result per string. Depends on ipv4p_pkg.
//
//  channel  | dir | payload                                   | end marker
//  req_     | in  | tdata[7:0] character                      | tlast = last byte
//  rsp_     | out | tdata[1:0] status, [33:2] address,        | one per string
//           |     | [36:34] part_count, [39:37] zero          |
//
// One byte per cycle unless a last byte stalls; a byte is held in the input register and the
// parse step runs from there into the state and result registers.
// A result is valid from the edge that moves its last byte out of the input register.
// Stalls: only a last byte waits on a full, untaken result register.
// Reset returns the parser to the start of a string with no result pending.
module ipv4_dotted_text_parser #(
   parameter int MAX_CHARS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [1:0] status, [33:2] address, [36:34] part_count
);
   import ipv4p_pkg::*;

   localparam int CW = $clog2(MAX_CHARS + 1);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_char_ff;
   logic             in_last_ff;
   state_type        state_ff, state_in;
   logic [CW-1:0]    chars_ff, chars_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff;
   result_type       result;
   state_type        step_state;
   logic             consume;
   logic             req_take;

   assign consume    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || consume;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (consume ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (consume && in_last_ff) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      step_state = state_ff;
      chars_in   = chars_ff;
      result     = '0;
      if (step_state.phase != PH_DONE) begin
         if (chars_ff >= CW'(MAX_CHARS) || in_char_ff == CH_NUL) begin
            step_state = end_string(step_state);
         end else begin
            chars_in   = chars_ff + CW'(1);
            step_state = feed(step_state, in_char_ff);
         end
      end
      state_in = step_state;
      if (in_last_ff) begin
         if (step_state.phase != PH_DONE) step_state = end_string(step_state);
         result   = build_result(step_state);
         state_in = STATE_RESET;
         chars_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
         chars_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (consume) begin
            state_ff <= state_in;
            chars_ff <= chars_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (consume && in_last_ff) rsp_data_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_data_ff};

   a_parts_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff.parts_done <= PART_MAX)
      else $error("parts_done above four");

   a_value_saturates: assert property (@(posedge clock) disable iff (reset)
      state_ff.part_value <= PART_LIMIT)
      else $error("part value above saturation limit");

   a_error_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != ST_OK |-> rsp_data_ff.address == 32'd0)
      else $error("failed parse carries an address");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      consume && in_last_ff |=> state_ff.phase == PH_START && chars_ff == '0
                                && state_ff.error_code == ST_OK)
      else $error("state not cleared after string end");

   a_last_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      consume && in_last_ff |=> rsp_valid_ff)
      else $error("string end gave no result");

endmodule
